// ===== rtl/core/assert_macros.svh =====
// Assertion helpers, clocked on clk with the active-low reset disabling them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RAD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RAD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rad_pkg.sv =====
package rad_pkg;

    localparam int SRC_W   = 11;
    localparam int THB_W   = 9;
    localparam int PIX_W   = 16;
    localparam int CH_W    = 6;
    localparam int ONE_W   = 17;
    localparam int XW      = SRC_W + 16;
    localparam int AREA_W  = 2 * ONE_W - 1;
    localparam int TOT_W   = 2 * XW - 1;
    localparam int ACC_W   = 2 * XW + 5;
    localparam int NUM_W   = ACC_W + 1;
    localparam int Q_W     = 6;
    localparam int NCH     = 3;
    localparam int CFG_IDX_W = 3;

    localparam int DEF_MAX_SOURCE_DIM  = 1024;
    localparam int DEF_MAX_THUMB_WIDTH = 256;

    localparam logic [SRC_W-1:0] RST_SOURCE_WIDTH  = SRC_W'(320);
    localparam logic [SRC_W-1:0] RST_SOURCE_HEIGHT = SRC_W'(240);
    localparam logic [THB_W-1:0] RST_THUMB_WIDTH   = THB_W'(64);
    localparam logic [THB_W-1:0] RST_THUMB_HEIGHT  = THB_W'(40);

    localparam logic [XW-1:0]    ONE16 = XW'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_THUMB_WIDTH   = 3'd2,
        CFG_THUMB_HEIGHT  = 3'd3
    } cfg_idx_t;

    // One classified source pixel, as handed from front to back.
    typedef struct packed {
        logic              bad;
        logic [4:0]        r;
        logic [5:0]        g;
        logic [4:0]        b;
        logic [THB_W-1:0]  dx;
        logic              bank;
        logic [ONE_W-1:0]  wx0;
        logic [ONE_W-1:0]  wx1;
        logic [ONE_W-1:0]  wy0;
        logic [ONE_W-1:0]  wy1;
        logic              fx0;
        logic              fy0;
        logic              emit;
        logic              last;
        logic [XW-1:0]     xspan;
        logic [XW-1:0]     yspan;
    } rad_job_t;

endpackage

// ===== rtl/core/rad_front.sv =====
module rad_front
    import rad_pkg::*;
#(
    parameter int MAX_SOURCE_DIM  = DEF_MAX_SOURCE_DIM,
    parameter int MAX_THUMB_WIDTH = DEF_MAX_THUMB_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SRC_W-1:0]     cfg_data,
    input  logic                 source_valid,
    output logic                 source_ready,
    input  logic [PIX_W-1:0]     source_pixel,
    output logic                 job_valid,
    input  logic                 job_ready,
    output rad_job_t             job
);

    localparam int DCW = $clog2(XW + 1);

    logic [SRC_W-1:0] sw_reg, sh_reg;
    logic [THB_W-1:0] tw_reg, th_reg;
    logic [XW-1:0]    hstep_reg, vstep_reg;
    logic [THB_W-1:0] hrem_reg, vrem_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic [SRC_W-1:0] col_reg, row_reg;
    logic [THB_W-1:0] dx_reg, dy_reg;
    logic [XW-1:0]    xa0_reg, ya0_reg;

    logic             busy, restart, accept, bad;
    logic [XW-1:0]    hdvd, vdvd;
    logic [THB_W:0]   htrial, vtrial;
    logic [PIX_W-1:0] px;
    logic [XW-1:0]    sx16, sy16, sx1, sy1, w16, h16, xedge, yedge, x1a, y1a, x1m, y1m;
    logic             xlast, ylast, has_x1, has_y1, col_end, row_end;

    assign busy    = div_cnt_reg != '0;
    assign restart = cfg_write_en && (cfg_index == CFG_SOURCE_WIDTH ||
                     cfg_index == CFG_SOURCE_HEIGHT || cfg_index == CFG_THUMB_WIDTH ||
                     cfg_index == CFG_THUMB_HEIGHT);

    assign source_ready = !busy && job_ready;
    assign job_valid    = source_valid && !busy;
    assign accept       = source_valid && source_ready;

    assign bad = sw_reg == '0 || sh_reg == '0 || tw_reg == '0 || th_reg == '0 ||
                 32'(sw_reg) > 32'(MAX_SOURCE_DIM) || 32'(sh_reg) > 32'(MAX_SOURCE_DIM) ||
                 32'(tw_reg) > 32'(MAX_THUMB_WIDTH) ||
                 32'(tw_reg) > 32'(sw_reg) || 32'(th_reg) > 32'(sh_reg);

    // step = (size << 16) / thumb, one quotient bit a cycle
    assign hdvd   = {sw_reg, 16'd0};
    assign vdvd   = {sh_reg, 16'd0};
    assign htrial = {hrem_reg, hdvd[div_cnt_reg - 1'b1]};
    assign vtrial = {vrem_reg, vdvd[div_cnt_reg - 1'b1]};

    assign px   = {source_pixel[7:0], source_pixel[15:8]};
    assign sx16 = {col_reg, 16'd0};
    assign sy16 = {row_reg, 16'd0};
    assign sx1  = sx16 + ONE16;
    assign sy1  = sy16 + ONE16;
    assign w16  = {sw_reg, 16'd0};
    assign h16  = {sh_reg, 16'd0};
    assign xedge = xa0_reg + hstep_reg;
    assign yedge = ya0_reg + vstep_reg;
    assign xlast = (THB_W+1)'(dx_reg) + 1'b1 >= (THB_W+1)'(tw_reg);
    assign ylast = (THB_W+1)'(dy_reg) + 1'b1 >= (THB_W+1)'(th_reg);
    assign x1a   = xlast ? w16 : xedge;
    assign y1a   = ylast ? h16 : yedge;
    assign x1m   = x1a - XW'(1);
    assign y1m   = y1a - XW'(1);
    assign has_x1 = !xlast && (sx1 > xedge);
    assign has_y1 = !ylast && (sy1 > yedge);
    assign col_end = (SRC_W+1)'(col_reg) + 1'b1 >= (SRC_W+1)'(sw_reg);
    assign row_end = (SRC_W+1)'(row_reg) + 1'b1 >= (SRC_W+1)'(sh_reg);

    always_comb
    begin
        job.bad   = bad;
        job.r     = px[15:11];
        job.g     = px[10:5];
        job.b     = px[4:0];
        job.dx    = dx_reg;
        job.bank  = dy_reg[0];
        job.wx0   = (x1a < sx1) ? ONE_W'(x1a - sx16) : ONE_W'(ONE16);
        job.wx1   = has_x1 ? ONE_W'(sx1 - xedge) : '0;
        job.wy0   = (y1a < sy1) ? ONE_W'(y1a - sy16) : ONE_W'(ONE16);
        job.wy1   = has_y1 ? ONE_W'(sy1 - yedge) : '0;
        job.fx0   = col_reg == xa0_reg[XW-1:16];
        job.fy0   = row_reg == ya0_reg[XW-1:16];
        job.emit  = (col_reg == x1m[XW-1:16]) && (row_reg == y1m[XW-1:16]);
        job.last  = bad ? (col_end && row_end) : (xlast && ylast);
        job.xspan = x1a - xa0_reg;
        job.yspan = y1a - ya0_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg      <= RST_SOURCE_WIDTH;
            sh_reg      <= RST_SOURCE_HEIGHT;
            tw_reg      <= RST_THUMB_WIDTH;
            th_reg      <= RST_THUMB_HEIGHT;
            hstep_reg   <= '0;
            vstep_reg   <= '0;
            hrem_reg    <= '0;
            vrem_reg    <= '0;
            div_cnt_reg <= DCW'(XW);
            col_reg     <= '0;
            row_reg     <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
            xa0_reg     <= '0;
            ya0_reg     <= '0;
        end
        else if (restart)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SOURCE_WIDTH:  sw_reg <= cfg_data;
                CFG_SOURCE_HEIGHT: sh_reg <= cfg_data;
                CFG_THUMB_WIDTH:   tw_reg <= cfg_data[THB_W-1:0];
                CFG_THUMB_HEIGHT:  th_reg <= cfg_data[THB_W-1:0];
                default: ;
            endcase
            hstep_reg   <= '0;
            vstep_reg   <= '0;
            hrem_reg    <= '0;
            vrem_reg    <= '0;
            div_cnt_reg <= DCW'(XW);
            col_reg     <= '0;
            row_reg     <= '0;
            dx_reg      <= '0;
            dy_reg      <= '0;
            xa0_reg     <= '0;
            ya0_reg     <= '0;
        end
        else if (busy)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (htrial >= {1'b0, tw_reg})
            begin
                hrem_reg  <= THB_W'(htrial - {1'b0, tw_reg});
                hstep_reg <= {hstep_reg[XW-2:0], 1'b1};
            end
            else
            begin
                hrem_reg  <= htrial[THB_W-1:0];
                hstep_reg <= {hstep_reg[XW-2:0], 1'b0};
            end
            if (vtrial >= {1'b0, th_reg})
            begin
                vrem_reg  <= THB_W'(vtrial - {1'b0, th_reg});
                vstep_reg <= {vstep_reg[XW-2:0], 1'b1};
            end
            else
            begin
                vrem_reg  <= vtrial[THB_W-1:0];
                vstep_reg <= {vstep_reg[XW-2:0], 1'b0};
            end
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_reg <= '0;
                dx_reg  <= '0;
                xa0_reg <= '0;
                if (row_end)
                begin
                    row_reg <= '0;
                    dy_reg  <= '0;
                    ya0_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                    if (sy1 >= yedge && !ylast)
                    begin
                        dy_reg  <= dy_reg + 1'b1;
                        ya0_reg <= yedge;
                    end
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
                if (sx1 >= xedge && !xlast)
                begin
                    dx_reg  <= dx_reg + 1'b1;
                    xa0_reg <= xedge;
                end
            end
        end
    end

endmodule

// ===== rtl/core/rad_queue.sv =====
module rad_queue
    import rad_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  rad_job_t push_job,
    output logic     pop_valid,
    input  logic     pop_ready,
    output rad_job_t pop_job
);

    rad_job_t   slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push, pop;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== rtl/core/rad_back.sv =====
module rad_back
    import rad_pkg::*;
#(
    parameter int MAX_THUMB_WIDTH = DEF_MAX_THUMB_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    output logic             job_ready,
    input  rad_job_t         job,
    output logic             thumb_valid,
    input  logic             thumb_ready,
    output logic [PIX_W-1:0] thumb_pixel,
    output logic             frame_last,
    output logic             config_error
);

    localparam int TXW   = $clog2(MAX_THUMB_WIDTH);
    localparam int AW    = TXW + 1;
    localparam int DEPTH = 2 ** AW;

    typedef enum logic [2:0] {B_IDLE, B_RD, B_MUL, B_WR, B_DIV, B_OUT} bstate_t;

    logic [NCH*ACC_W-1:0] acc_mem [DEPTH];
    logic [NCH*ACC_W-1:0] rdata_reg;

    bstate_t          state_reg, state_next;
    rad_job_t         job_reg, job_next;
    logic [3:0]       mask_reg, mask_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [AREA_W-1:0] area_reg, area_next;
    logic             first_reg, first_next;
    logic             emit_reg, emit_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [ACC_W-1:0] prod_reg [NCH];
    logic [ACC_W-1:0] prod_next [NCH];
    logic [NUM_W-1:0] num_reg [NCH];
    logic [NUM_W-1:0] num_next [NCH];
    logic [Q_W-1:0]   q_reg [NCH];
    logic [Q_W-1:0]   q_next [NCH];
    logic [2:0]       cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pix_reg, out_pix_next;
    logic             out_last_reg, out_last_next;
    logic             out_err_reg, out_err_next;

    logic             si, sj, wr_en;
    logic [ONE_W-1:0] wx, wy;
    logic [2*ONE_W-1:0] area_full;
    logic [CH_W-1:0]  chv [NCH];
    logic [ACC_W-1:0] sum [NCH];
    logic [NUM_W-1:0] dsh [NCH];
    logic [2*XW-1:0]  tot_full;

    assign job_ready    = state_reg == B_IDLE;
    assign thumb_valid  = out_valid_reg;
    assign thumb_pixel  = out_pix_reg;
    assign frame_last   = out_last_reg;
    assign config_error = out_err_reg;

    // highest pending update first, so the (0,0) box that may finish goes last
    assign sj = mask_reg[3] || mask_reg[2];
    assign si = mask_reg[3] || (!mask_reg[2] && mask_reg[1]);
    assign wx = si ? job_reg.wx1 : job_reg.wx0;
    assign wy = sj ? job_reg.wy1 : job_reg.wy0;
    assign area_full = wx * wy;
    assign tot_full  = job_reg.xspan * job_reg.yspan;
    assign chv[0] = {1'b0, job_reg.r};
    assign chv[1] = job_reg.g;
    assign chv[2] = {1'b0, job_reg.b};
    assign wr_en  = state_reg == B_WR;

    always_comb
    begin
        for (int c = 0; c < NCH; c++)
        begin
            sum[c] = first_reg ? prod_reg[c] : rdata_reg[c*ACC_W +: ACC_W] + prod_reg[c];
            dsh[c] = NUM_W'(total_reg) << cnt_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        mask_next      = mask_reg;
        addr_next      = addr_reg;
        area_next      = area_reg;
        first_next     = first_reg;
        emit_next      = emit_reg;
        total_next     = total_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !thumb_ready;
        out_pix_next   = out_pix_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        for (int c = 0; c < NCH; c++)
        begin
            prod_next[c] = prod_reg[c];
            num_next[c]  = num_reg[c];
            q_next[c]    = q_reg[c];
        end
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_next  = job;
                    mask_next = {job.wx1 != '0 && job.wy1 != '0, job.wy1 != '0,
                                 job.wx1 != '0, 1'b1};
                    state_next = job.bad ? B_OUT : B_RD;
                end
            end
            B_RD:
            begin
                addr_next  = {job_reg.bank ^ sj, TXW'(job_reg.dx + THB_W'(si))};
                area_next  = area_full[AREA_W-1:0];
                first_next = (si || job_reg.fx0) && (sj || job_reg.fy0);
                emit_next  = !si && !sj && job_reg.emit;
                mask_next  = mask_reg & ~(4'b1 << {sj, si});
                state_next = B_MUL;
            end
            B_MUL:
            begin
                for (int c = 0; c < NCH; c++)
                    prod_next[c] = ACC_W'(chv[c]) * ACC_W'(area_reg);
                total_next = tot_full[TOT_W-1:0];
                state_next = B_WR;
            end
            B_WR:
            begin
                if (emit_reg)
                begin
                    for (int c = 0; c < NCH; c++)
                    begin
                        num_next[c] = NUM_W'(sum[c]) + NUM_W'(total_reg >> 1);
                        q_next[c]   = '0;
                    end
                    cnt_next   = 3'd5;
                    state_next = B_DIV;
                end
                else
                    state_next = (mask_reg != '0) ? B_RD : B_IDLE;
            end
            B_DIV:
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    if (num_reg[c] >= dsh[c])
                    begin
                        num_next[c]        = num_reg[c] - dsh[c];
                        q_next[c][cnt_reg] = 1'b1;
                    end
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!out_valid_reg || thumb_ready)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = job_reg.bad ? '0 :
                                     {q_reg[0][4:0], q_reg[1], q_reg[2][4:0]};
                    out_last_next  = job_reg.last;
                    out_err_next   = job_reg.bad;
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            acc_mem[addr_reg] <= {sum[2], sum[1], sum[0]};
        rdata_reg <= acc_mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            job_reg       <= '0;
            mask_reg      <= '0;
            addr_reg      <= '0;
            area_reg      <= '0;
            first_reg     <= 1'b0;
            emit_reg      <= 1'b0;
            total_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_pix_reg   <= '0;
            out_last_reg  <= 1'b0;
            out_err_reg   <= 1'b0;
            for (int c = 0; c < NCH; c++)
            begin
                prod_reg[c] <= '0;
                num_reg[c]  <= '0;
                q_reg[c]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            mask_reg      <= mask_next;
            addr_reg      <= addr_next;
            area_reg      <= area_next;
            first_reg     <= first_next;
            emit_reg      <= emit_next;
            total_reg     <= total_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_pix_reg   <= out_pix_next;
            out_last_reg  <= out_last_next;
            out_err_reg   <= out_err_next;
            for (int c = 0; c < NCH; c++)
            begin
                prod_reg[c] <= prod_next[c];
                num_reg[c]  <= num_next[c];
                q_reg[c]    <= q_next[c];
            end
        end
    end

endmodule

// ===== rtl/core/rgb565_area_downscaler.sv =====
// Channel   | Handshake                    | Payload
// cfg       | cfg_write_en                 | cfg_index, cfg_data
// source    | source_valid / source_ready  | source_pixel
// thumb     | thumb_valid / thumb_ready    | thumb_pixel, frame_last, config_error
//
// Front takes one request a cycle into a two-entry queue while it has room and no
// step division runs. The back end pops a job, runs read, multiply and write per
// box update (1 to 4 per pixel), then on a finished box a 6-step divider and
// output; a bad config pops straight to output. Reset and any write to a listed
// register run the step divider with source_ready low. Results sit in an output
// register, so the back end only waits on a stalled thumb when it has a result.
`include "assert_macros.svh"

module rgb565_area_downscaler
    import rad_pkg::*;
#(
    parameter int MAX_SOURCE_DIM  = DEF_MAX_SOURCE_DIM,
    parameter int MAX_THUMB_WIDTH = DEF_MAX_THUMB_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SRC_W-1:0]     cfg_data,
    input  logic                 source_valid,
    output logic                 source_ready,
    input  logic [PIX_W-1:0]     source_pixel,
    output logic                 thumb_valid,
    input  logic                 thumb_ready,
    output logic [PIX_W-1:0]     thumb_pixel,
    output logic                 frame_last,
    output logic                 config_error
);

    rad_job_t fq_job, qb_job;
    logic     fq_valid, fq_ready, qb_valid, qb_ready;

    rad_front #(
        .MAX_SOURCE_DIM  (MAX_SOURCE_DIM),
        .MAX_THUMB_WIDTH (MAX_THUMB_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .source_valid (source_valid),
        .source_ready (source_ready),
        .source_pixel (source_pixel),
        .job_valid    (fq_valid),
        .job_ready    (fq_ready),
        .job          (fq_job)
    );

    rad_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    rad_back #(
        .MAX_THUMB_WIDTH (MAX_THUMB_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (qb_valid),
        .job_ready    (qb_ready),
        .job          (qb_job),
        .thumb_valid  (thumb_valid),
        .thumb_ready  (thumb_ready),
        .thumb_pixel  (thumb_pixel),
        .frame_last   (frame_last),
        .config_error (config_error)
    );

    `RAD_ASSERT_NOW(a_err_pixel_zero, thumb_valid && config_error, thumb_pixel == '0, "error pixel not zero")
    `RAD_ASSERT_NEXT(a_cfg_blocks_source, cfg_write_en && cfg_index <= CFG_THUMB_HEIGHT, !source_ready, "source taken during step setup")
    `RAD_ASSERT_NOW(a_queue_push_ok, fq_valid && source_ready, fq_ready, "front pushed into full queue")

endmodule
